### src/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and constants of the bitmap ID allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

	localparam int ID_W     = 10;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;
	localparam int STATUS_W = 2;

	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [ID_W-1:0]     id_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_ALLOCATED = 2'd0;
	localparam status_t STATUS_EXHAUSTED = 2'd1;
	localparam status_t STATUS_FREED     = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

endpackage

### src/bitmap_id_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Next-fit ID allocator over a bitmap of 32-bit words held in one RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM clear, one word per cycle;
// s_tready stays low until then. One request is handled at a time. A free is
// accepted with its RAM read, then writes the word back (for an ID within the
// pool) and gives the result. An allocate reads bitmap words, 1 to WORDS of
// them, until a non-full word is found: the single RAM read port inspects one
// word per cycle, starting at the word cursor. A result that is not taken at
// once holds in the output register and stalls the next request only at its
// own final step.
module bitmap_id_allocator #(
	parameter int WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] free_id
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] granted_id
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IW = (AW > bia_pkg::BIT_W) ? AW : bia_pkg::BIT_W;
	localparam int CW = $clog2(WORDS + 1);
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
	localparam logic [CW-1:0] LAST_CNT  = CW'(WORDS - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_FREE  = 2'd2;
	localparam logic [1:0] ST_SCAN  = 2'd3;

	logic [1:0]                 state_q;
	logic [AW-1:0]              w_q;
	logic [AW-1:0]              cursor_q;
	logic [CW-1:0]              n_q;
	logic [bia_pkg::BIT_W-1:0]  fbit_q;
	logic                       frange_q;
	logic                       out_valid_q;
	bia_pkg::id_t               out_id_q;
	bia_pkg::status_t           out_status_q;

	logic                       accept;
	logic                       slot_free;
	logic                       done;
	logic [IW-1:0]              fidx_ext;
	logic                       fid_in_range;
	logic [AW-1:0]              w_next;
	bia_pkg::word_t             rd_data;
	logic                       word_full;
	logic [bia_pkg::BIT_W-1:0]  low_bit;
	logic [IW-1:0]              w_ext;
	logic                       re;
	logic [AW-1:0]              raddr;
	logic                       we;
	logic [AW-1:0]              waddr;
	bia_pkg::word_t             wdata;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign done      = slot_free && ((state_q == ST_FREE) ||
		(state_q == ST_SCAN && !(word_full && n_q != LAST_CNT)));

	assign fidx_ext     = IW'(s_tdata[9:bia_pkg::BIT_W]);
	assign fid_in_range = (32'(s_tdata[9:bia_pkg::BIT_W]) < 32'(WORDS));
	assign w_next       = (w_q == LAST_WORD) ? '0 : w_q + AW'(1);
	assign word_full    = (rd_data == '1);
	assign w_ext        = IW'(w_q);

	// lowest clear bit of the word under inspection
	always_comb begin
		low_bit = '0;
		for (int b = bia_pkg::WORD_W - 1; b >= 0; b--) begin
			if (!rd_data[b])
				low_bit = bia_pkg::BIT_W'(b);
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = cursor_q;
		we    = 1'b0;
		waddr = w_q;
		wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				re    = accept;
				raddr = (s_tuser == bia_pkg::MODE_FREE) ? fidx_ext[AW-1:0] : cursor_q;
			end
			ST_FREE: begin
				we    = slot_free && frange_q;
				wdata = rd_data & ~(bia_pkg::word_t'(1) << fbit_q);
			end
			ST_SCAN: begin
				if (word_full) begin
					re    = (n_q != LAST_CNT);
					raddr = w_next;
				end else begin
					we    = slot_free;
					wdata = rd_data | (bia_pkg::word_t'(1) << low_bit);
				end
			end
			default: ;
		endcase
	end

	bia_ram #(
		.WIDTH(bia_pkg::WORD_W),
		.DEPTH(WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			w_q         <= '0;
			cursor_q    <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					w_q <= w_next;
					if (w_q == LAST_WORD)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						n_q <= '0;
						w_q <= (s_tuser == bia_pkg::MODE_FREE) ? fidx_ext[AW-1:0] : cursor_q;
						state_q <= (s_tuser == bia_pkg::MODE_FREE) ? ST_FREE : ST_SCAN;
					end
				end
				ST_FREE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (word_full && n_q != LAST_CNT) begin
						w_q <= w_next;
						n_q <= n_q + CW'(1);
					end else if (slot_free) begin
						// done: cursor to last word read (if exhausted, the one before the start)
						cursor_q <= w_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			fbit_q   <= s_tdata[bia_pkg::BIT_W-1:0];
			frange_q <= fid_in_range;
		end
		if (state_q == ST_FREE && slot_free) begin
			out_id_q     <= '0;
			out_status_q <= bia_pkg::STATUS_FREED;
		end else if (state_q == ST_SCAN && slot_free && !(word_full && n_q != LAST_CNT)) begin
			if (word_full) begin
				out_id_q     <= '0;
				out_status_q <= bia_pkg::STATUS_EXHAUSTED;
			end else begin
				out_id_q     <= {w_ext[bia_pkg::BIT_W-1:0], low_bit};
				out_status_q <= bia_pkg::STATUS_ALLOCATED;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_id_q};
	assign m_tuser  = out_status_q;

`ifndef NO_ASSERTIONS
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !we)
		else $error("bitmap write while idle");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (n_q <= LAST_CNT))
		else $error("scan ran past the pool");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_q) < 32'(WORDS))
		else $error("cursor out of range");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_FREE || state_q == ST_SCAN))
		else $error("request not taken into work");
`endif

endmodule

### src/bia_ram.sv
// ----------------------------------------------------------------------------
// bia_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
